// File: rtl/cfk_pkg.sv
// Shared widths and arithmetic step functions for the cylindrical Fresnel kernel.
// Used by cfk_sqrt2, cfk_div and cylindrical_fresnel_kernel_top.
package cfk_pkg;

  localparam int LEN_W   = 48;             // input lengths and psi
  localparam int K_W     = 32;             // wavenumber, Q24.8
  localparam int K_FRAC  = 8;              // fraction bits of the wavenumber
  localparam int DIF_W   = LEN_W + 1;      // signed coordinate differences
  localparam int MAG_W   = DIF_W;          // magnitude of a difference
  localparam int LO_W    = 32;             // low slice for the split multipliers
  localparam int HI_W    = MAG_W - LO_W;
  localparam int SQ_W    = 2 * LEN_W + 2;  // sum of squares, unsigned
  localparam int DOT_W   = SQ_W + 2;       // dot product, signed
  localparam int ROOT_W  = SQ_W / 2;       // integer square root
  localparam int REM_W   = ROOT_W + 2;     // square root partial remainder
  localparam int Q_W     = ROOT_W + 1;     // quotient of dot by |u|
  localparam int DIFF_W  = Q_W + 2;        // signed |d| - q
  localparam int DMAG_W  = DIFF_W - 1;
  localparam int DHI_W   = DMAG_W - LO_W;
  localparam int PR_W    = K_W + DMAG_W + 1;
  localparam int PS_W    = PR_W - K_FRAC;

  localparam logic [LEN_W-1:0] PSI_MAX = {1'b0, {(LEN_W-1){1'b1}}};
  localparam logic [LEN_W-1:0] PSI_MIN = {1'b1, {(LEN_W-1){1'b0}}};

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIF_W-1:0] x);
    logic [DIF_W-1:0] n;
    n = -x;
    return x[DIF_W-1] ? n : x;
  endfunction

  // One digit of a restoring square root: returns {remainder, root}.
  function automatic logic [REM_W+ROOT_W-1:0] sqrt_step(input logic [REM_W-1:0] rem,
                                                        input logic [ROOT_W-1:0] root,
                                                        input logic [1:0] bits);
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] d;
    r2 = {rem, bits};
    t  = {{(REM_W-ROOT_W-1){1'b0}}, root, 2'b01};
    d  = r2 - t;
    if (r2 >= t) begin
      return {d[REM_W-1:0], root[ROOT_W-2:0], 1'b1};
    end else begin
      return {r2[REM_W-1:0], root[ROOT_W-2:0], 1'b0};
    end
  endfunction

  // One bit of a restoring division: returns {remainder, quotient bit}.
  function automatic logic [ROOT_W:0] div_step(input logic [ROOT_W-1:0] rem,
                                               input logic [ROOT_W-1:0] dvs,
                                               input logic b);
    logic [ROOT_W:0] r2;
    logic [ROOT_W:0] d;
    r2 = {rem, b};
    d  = r2 - {1'b0, dvs};
    if (r2 >= {1'b0, dvs}) begin
      return {d[ROOT_W-1:0], 1'b1};
    end else begin
      return {r2[ROOT_W-1:0], 1'b0};
    end
  endfunction

endpackage

// File: rtl/cfk_sqrt2.sv
// Two-lane pipelined integer square root, one root bit per stage.
// Depends on cfk_pkg; carries a sideband word alongside each item.
module cfk_sqrt2 import cfk_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_num_a,
  input  logic [SQ_W-1:0]   in_num_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root_a,
  output logic [ROOT_W-1:0] out_root_b,
  output logic [SIDE_W-1:0] out_side
);

  localparam int N = ROOT_W;

  logic [N-1:0]      vld;
  logic [SQ_W-1:0]   num_a  [N];
  logic [SQ_W-1:0]   num_b  [N];
  logic [REM_W-1:0]  rem_a  [N];
  logic [REM_W-1:0]  rem_b  [N];
  logic [ROOT_W-1:0] root_a [N];
  logic [ROOT_W-1:0] root_b [N];
  logic [SIDE_W-1:0] side   [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic              pv;
    logic [SQ_W-1:0]   pa, pb;
    logic [REM_W-1:0]  ra, rb;
    logic [ROOT_W-1:0] qa, qb;
    logic [SIDE_W-1:0] ps;
    logic [REM_W+ROOT_W-1:0] sa, sb;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign pa = in_num_a;
      assign pb = in_num_b;
      assign ra = '0;
      assign rb = '0;
      assign qa = '0;
      assign qb = '0;
      assign ps = in_side;
    end else begin : g_next
      assign pv = vld[i-1];
      assign pa = num_a[i-1];
      assign pb = num_b[i-1];
      assign ra = rem_a[i-1];
      assign rb = rem_b[i-1];
      assign qa = root_a[i-1];
      assign qb = root_b[i-1];
      assign ps = side[i-1];
    end

    assign sa = sqrt_step(ra, qa, pa[2*(N-1-i)+1 -: 2]);
    assign sb = sqrt_step(rb, qb, pb[2*(N-1-i)+1 -: 2]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= pv;
      end
      num_a[i]  <= pa;
      num_b[i]  <= pb;
      rem_a[i]  <= sa[REM_W+ROOT_W-1:ROOT_W];
      rem_b[i]  <= sb[REM_W+ROOT_W-1:ROOT_W];
      root_a[i] <= sa[ROOT_W-1:0];
      root_b[i] <= sb[ROOT_W-1:0];
      side[i]   <= ps;
    end
  end

  assign out_valid  = vld[N-1];
  assign out_root_a = root_a[N-1];
  assign out_root_b = root_b[N-1];
  assign out_side   = side[N-1];

endmodule

// File: rtl/cfk_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cfk_pkg; carries a sideband word alongside each item.
module cfk_div import cfk_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_dividend,
  input  logic [ROOT_W-1:0] in_divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int N = Q_W;

  logic [N-1:0]      vld;
  logic [SQ_W-1:0]   dvd  [N];
  logic [ROOT_W-1:0] dvs  [N];
  logic [ROOT_W-1:0] rem  [N];
  logic [Q_W-1:0]    quot [N];
  logic [SIDE_W-1:0] side [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic              pv;
    logic [SQ_W-1:0]   pd;
    logic [ROOT_W-1:0] pz, pr;
    logic [Q_W-1:0]    pq;
    logic [SIDE_W-1:0] ps;
    logic [ROOT_W:0]   st;

    if (i == 0) begin : g_first
      // The quotient is known to fit Q_W bits, so the upper dividend bits start below the divisor.
      assign pv = in_valid;
      assign pd = in_dividend;
      assign pz = in_divisor;
      assign pr = {{(ROOT_W-SQ_W+Q_W){1'b0}}, in_dividend[SQ_W-1:Q_W]};
      assign pq = '0;
      assign ps = in_side;
    end else begin : g_next
      assign pv = vld[i-1];
      assign pd = dvd[i-1];
      assign pz = dvs[i-1];
      assign pr = rem[i-1];
      assign pq = quot[i-1];
      assign ps = side[i-1];
    end

    assign st = div_step(pr, pz, pd[N-1-i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= pv;
      end
      dvd[i]  <= pd;
      dvs[i]  <= pz;
      rem[i]  <= st[ROOT_W:1];
      quot[i] <= {pq[Q_W-2:0], st[0]};
      side[i] <= ps;
    end
  end

  assign out_valid = vld[N-1];
  assign out_quot  = quot[N-1];
  assign out_side  = side[N-1];

endmodule

// File: rtl/cylindrical_fresnel_kernel_top.sv
// Cylindrical Fresnel kernel phase, fully pipelined.
// Depends on cfk_pkg, cfk_sqrt2 and cfk_div.
//
// The block takes one item in every clock cycle: busy never rises, so start may be held
// high for a whole stream. Each item gives its result with done high for a single cycle;
// the receiver cannot stall the pipeline. The pipeline is made of the square root
// pipeline (one root bit per stage, 49 stages) and the divider that follows it (one
// quotient bit per stage, 50 stages), plus twelve stages of differences, split
// multiplications, sums, rounding and saturation. Results leave in input order.
module cylindrical_fresnel_kernel_top import cfk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [K_W-1:0]          wavenumber,
  input  logic signed [LEN_W-1:0] observer_x,
  input  logic signed [LEN_W-1:0] observer_y,
  input  logic signed [LEN_W-1:0] observer_z,
  input  logic signed [LEN_W-1:0] intercept_x,
  input  logic signed [LEN_W-1:0] intercept_y,
  input  logic signed [LEN_W-1:0] point_x,
  input  logic signed [LEN_W-1:0] point_y,
  output logic                    done,
  output logic signed [LEN_W-1:0] psi,
  output logic                    fault
);

  localparam int NP      = 7;
  localparam int SIDE1_W = 1 + K_W + DOT_W;
  localparam int SIDE2_W = 1 + K_W + 1 + ROOT_W;

  assign busy = 1'b0;

  // Differences.
  logic                    v1;
  logic [K_W-1:0]          k1;
  logic signed [DIF_W-1:0] ux1, uy1, uz1, dx1, dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    k1  <= wavenumber;
    ux1 <= {observer_x[LEN_W-1], observer_x} - {intercept_x[LEN_W-1], intercept_x};
    uy1 <= {observer_y[LEN_W-1], observer_y} - {intercept_y[LEN_W-1], intercept_y};
    uz1 <= {observer_z[LEN_W-1], observer_z};
    dx1 <= {observer_x[LEN_W-1], observer_x} - {point_x[LEN_W-1], point_x};
    dy1 <= {observer_y[LEN_W-1], observer_y} - {point_y[LEN_W-1], point_y};
  end

  // Magnitudes and signs of the multiplier operands.
  logic             v2, zero2;
  logic [K_W-1:0]   k2;
  logic [MAG_W-1:0] aux2, auy2, auz2, adx2, ady2;
  logic [1:0]       sn2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    k2    <= k1;
    zero2 <= (ux1 == '0) && (uy1 == '0) && (uz1 == '0);
    aux2  <= mag(ux1);
    auy2  <= mag(uy1);
    auz2  <= mag(uz1);
    adx2  <= mag(dx1);
    ady2  <= mag(dy1);
    sn2   <= {uy1[DIF_W-1] ^ dy1[DIF_W-1], ux1[DIF_W-1] ^ dx1[DIF_W-1]};
  end

  // Products: ux^2, uy^2, uz^2, dx^2, dy^2, ux*dx, uy*dy.
  logic [MAG_W-1:0] opa [NP];
  logic [MAG_W-1:0] opb [NP];

  always_comb begin
    opa[0] = aux2; opb[0] = aux2;
    opa[1] = auy2; opb[1] = auy2;
    opa[2] = auz2; opb[2] = auz2;
    opa[3] = adx2; opb[3] = adx2;
    opa[4] = ady2; opb[4] = ady2;
    opa[5] = aux2; opb[5] = adx2;
    opa[6] = auy2; opb[6] = ady2;
  end

  logic                    v3, zero3;
  logic [K_W-1:0]          k3;
  logic [1:0]              sn3;
  logic [2*LO_W-1:0]       pll3 [NP];
  logic [LO_W+HI_W-1:0]    plh3 [NP];
  logic [LO_W+HI_W-1:0]    phl3 [NP];
  logic [2*HI_W-1:0]       phh3 [NP];
  logic [SQ_W-1:0]         prod4 [NP];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    k3    <= k2;
    zero3 <= zero2;
    sn3   <= sn2;
    for (int i = 0; i < NP; i++) begin
      pll3[i] <= opa[i][LO_W-1:0] * opb[i][LO_W-1:0];
      plh3[i] <= opa[i][LO_W-1:0] * opb[i][MAG_W-1:LO_W];
      phl3[i] <= opa[i][MAG_W-1:LO_W] * opb[i][LO_W-1:0];
      phh3[i] <= opa[i][MAG_W-1:LO_W] * opb[i][MAG_W-1:LO_W];
    end
  end

  logic           v4, zero4;
  logic [K_W-1:0] k4;
  logic [1:0]     sn4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    k4    <= k3;
    zero4 <= zero3;
    sn4   <= sn3;
    for (int i = 0; i < NP; i++) begin
      prod4[i] <= SQ_W'(pll3[i]) + (SQ_W'(plh3[i]) << LO_W) + (SQ_W'(phl3[i]) << LO_W)
                + (SQ_W'(phh3[i]) << (2 * LO_W));
    end
  end

  // Sums of squares and signed dot terms.
  logic                    v5, zero5;
  logic [K_W-1:0]          k5;
  logic [SQ_W-1:0]         su5, sd5, uzz5;
  logic signed [DOT_W-1:0] dta5, dtb5;
  logic signed [DOT_W-1:0] pa5, pb5;

  always_comb begin
    pa5 = $signed({2'b00, prod4[5]});
    pb5 = $signed({2'b00, prod4[6]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    k5    <= k4;
    zero5 <= zero4;
    su5   <= prod4[0] + prod4[1] + prod4[2];
    sd5   <= prod4[3] + prod4[4] + prod4[2];
    uzz5  <= prod4[2];
    dta5  <= sn4[0] ? -pa5 : pa5;
    dtb5  <= sn4[1] ? -pb5 : pb5;
  end

  logic                    v6, zero6;
  logic [K_W-1:0]          k6;
  logic [SQ_W-1:0]         su6, sd6;
  logic signed [DOT_W-1:0] dot6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    k6    <= k5;
    zero6 <= zero5;
    su6   <= su5;
    sd6   <= sd5;
    dot6  <= dta5 + dtb5 + $signed({2'b00, uzz5});
  end

  // Square roots of |u|^2 and |d|^2.
  logic               vs;
  logic [ROOT_W-1:0]  nu_s, nd_s;
  logic [SIDE1_W-1:0] side_s;

  cfk_sqrt2 #(
    .SIDE_W(SIDE1_W)
  ) u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v6),
    .in_num_a   (su6),
    .in_num_b   (sd6),
    .in_side    ({zero6, k6, dot6}),
    .out_valid  (vs),
    .out_root_a (nu_s),
    .out_root_b (nd_s),
    .out_side   (side_s)
  );

  logic              v7, zero7, dneg7;
  logic [K_W-1:0]    k7;
  logic [SQ_W-1:0]   adot7;
  logic [ROOT_W-1:0] nu7, nd7;
  logic [DOT_W-1:0]  dot_s, ndot_s;

  assign dot_s  = side_s[DOT_W-1:0];
  assign ndot_s = -dot_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= vs;
    end
    zero7 <= side_s[SIDE1_W-1];
    k7    <= side_s[DOT_W +: K_W];
    dneg7 <= dot_s[DOT_W-1];
    adot7 <= dot_s[DOT_W-1] ? ndot_s[SQ_W-1:0] : dot_s[SQ_W-1:0];
    nu7   <= nu_s;
    nd7   <= nd_s;
  end

  // Quotient of the dot product by |u|; a zero |u| gives a meaningless quotient.
  logic               vq;
  logic [Q_W-1:0]     q_q;
  logic [SIDE2_W-1:0] side_q;

  cfk_div #(
    .SIDE_W(SIDE2_W)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v7),
    .in_dividend (adot7),
    .in_divisor  (nu7),
    .in_side     ({zero7, k7, dneg7, nd7}),
    .out_valid   (vq),
    .out_quot    (q_q),
    .out_side    (side_q)
  );

  logic                     v8, zero8;
  logic [K_W-1:0]           k8;
  logic signed [DIFF_W-1:0] diff8;
  logic signed [DIFF_W-1:0] qs_q;
  logic signed [DIFF_W-1:0] qp_q;
  logic                     dneg_q;

  assign dneg_q = side_q[ROOT_W];
  assign qp_q   = $signed({2'b00, q_q});
  assign qs_q   = dneg_q ? -qp_q : qp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= vq;
    end
    zero8 <= side_q[SIDE2_W-1];
    k8    <= side_q[ROOT_W+1 +: K_W];
    diff8 <= $signed({{(DIFF_W-ROOT_W){1'b0}}, side_q[ROOT_W-1:0]}) - qs_q;
  end

  // Scale by k, round the magnitude to nearest with ties away from zero, then saturate.
  logic              v9, zero9, neg9;
  logic [K_W-1:0]    k9;
  logic [DMAG_W-1:0] dmag9;
  logic [DIFF_W-1:0] ndiff8;

  assign ndiff8 = -diff8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    zero9 <= zero8;
    k9    <= k8;
    neg9  <= diff8[DIFF_W-1];
    dmag9 <= diff8[DIFF_W-1] ? ndiff8[DMAG_W-1:0] : diff8[DMAG_W-1:0];
  end

  logic                  v10, zero10, neg10;
  logic [K_W+LO_W-1:0]   pl10;
  logic [K_W+DHI_W-1:0]  ph10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    zero10 <= zero9;
    neg10  <= neg9;
    pl10   <= k9 * dmag9[LO_W-1:0];
    ph10   <= k9 * dmag9[DMAG_W-1:LO_W];
  end

  logic            v11, zero11, neg11;
  logic [PS_W-1:0] ps11;
  logic [PR_W-1:0] pr10;

  assign pr10 = PR_W'(pl10) + (PR_W'(ph10) << LO_W) + (PR_W'(1) << (K_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= v10;
    end
    zero11 <= zero10;
    neg11  <= neg10;
    ps11   <= pr10[PR_W-1:K_FRAC];
  end

  logic [LEN_W-1:0] lim11, val11, nval11;
  logic             sat11;

  always_comb begin
    lim11  = neg11 ? PSI_MIN : PSI_MAX;
    sat11  = ps11 > PS_W'(lim11);
    val11  = sat11 ? lim11 : ps11[LEN_W-1:0];
    nval11 = -val11;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v11;
    end
    if (zero11) begin
      psi   <= '0;
      fault <= 1'b1;
    end else begin
      psi   <= neg11 ? nval11 : val11;
      fault <= sat11;
    end
  end

endmodule
